[rtl/core/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int INDEX_W   = 11;
  localparam int CELL_W    = 16;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  localparam logic [OPCODE_W-1:0] OP_PUT       = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BACKSPACE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ      = 2'd3;

  localparam logic [COLOR_W-1:0] CLEAR_COLOR      = 8'h0F;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE       = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_RETURN        = 8'd13;
  localparam logic [CHAR_W-1:0]  CH_SPACE         = 8'd32;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the incoming request
    logic exec_put;    // put character at the cursor
    logic exec_bs;     // backspace
    logic exec_clear;  // home the cursor
    logic rd_cell;     // read the requested cell
    logic copy_step;   // scroll: move one cell up a row
    logic fill_step;   // scroll: blank one cell of the bottom row
    logic clear_step;  // clear: blank one cell with the clear colour
    logic load_out;    // load the result register
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                scroll_need;
    logic                copy_last;
    logic                sweep_last;
  } tcw_sts_t;

endpackage

`default_nettype wire

[rtl/core/tcw_ram.sv]
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcw_datapath.sv]
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [COLOR_W-1:0]   cfg_wdata_i,
  input  wire logic [OPCODE_W-1:0]  opcode_i,
  input  wire logic [CHAR_W-1:0]    char_code_i,
  input  wire logic [INDEX_W-1:0]   cell_index_i,
  input  wire tcw_cmd_t             cmd_i,
  output tcw_sts_t                  sts_o,
  output logic      [COL_OUT_W-1:0] cursor_column_o,
  output logic      [ROW_OUT_W-1:0] cursor_row_o,
  output logic      [CELL_W-1:0]    cell_data_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CMP_W = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  logic [COLOR_W-1:0]  color_q;
  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [OPCODE_W-1:0] opcode_q;
  logic [CHAR_W-1:0]   char_q;
  logic [INDEX_W-1:0]  index_q;
  logic [AW-1:0]       sweep_q, sweep_d;
  logic                copy_pend_q;
  logic [AW-1:0]       copy_addr_q;
  logic                rd_hit_q;

  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     bs_addr;
  logic              is_nl, is_cr, printable, row_wrap, index_hit;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign cur_addr  = AW'(row_q) * COLS_A + AW'(col_q);
  assign bs_addr   = (cur_addr == '0) ? '0 : cur_addr - AW'(1);
  assign is_nl     = (char_q == CH_NEWLINE);
  assign is_cr     = (char_q == CH_RETURN);
  assign printable = !is_nl && !is_cr;
  assign row_wrap  = is_nl || (printable && (col_q == COL_LAST));
  assign index_hit = CMP_W'(index_q) < CMP_W'(CELLS);

  assign sts_o.op          = opcode_q;
  assign sts_o.scroll_need = row_wrap && (row_q == ROW_LAST);
  assign sts_o.copy_last   = (sweep_q == COPY_LAST);
  assign sts_o.sweep_last  = (sweep_q == LAST_CELL);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.exec_put) begin
      if (row_wrap) begin
        col_d = '0;
        if (row_q != ROW_LAST) begin
          row_d = row_q + RW'(1);
        end
      end else if (printable) begin
        col_d = col_q + CW'(1);
      end else begin
        col_d = '0;
      end
    end else if (cmd_i.exec_bs) begin
      if ((col_q == '0) && (row_q != '0)) begin
        row_d = row_q - RW'(1);
        col_d = COL_LAST;
      end else if (col_q != '0) begin
        col_d = col_q - CW'(1);
      end
    end else if (cmd_i.exec_clear) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // Single write port: a pending scroll copy always wins
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {color_q, CH_SPACE};
    if (copy_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = copy_addr_q;
      ram_wdata = ram_rdata;
    end else if (cmd_i.exec_put && printable) begin
      ram_we    = 1'b1;
      ram_wdata = {color_q, char_q};
    end else if (cmd_i.exec_bs) begin
      ram_we    = 1'b1;
      ram_waddr = bs_addr;
    end else if (cmd_i.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
    end else if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = {CLEAR_COLOR, CH_SPACE};
    end
  end

  assign ram_re    = cmd_i.copy_step || (cmd_i.rd_cell && index_hit);
  assign ram_raddr = cmd_i.copy_step ? (sweep_q + COLS_A) : AW'(index_q);

  always_comb begin
    sweep_d = sweep_q;
    if (cmd_i.copy_step) begin
      sweep_d = sweep_q + AW'(1);
    end else if (cmd_i.fill_step || cmd_i.clear_step) begin
      // wrap so that the next copy or clear sweep starts from cell 0
      sweep_d = (sweep_q == LAST_CELL) ? '0 : sweep_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= TEXT_COLOR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      sweep_q     <= '0;
      copy_pend_q <= 1'b0;
      rd_hit_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      col_q       <= col_d;
      row_q       <= row_d;
      sweep_q     <= sweep_d;
      copy_pend_q <= cmd_i.copy_step;
      if (cmd_i.capture) begin
        rd_hit_q <= 1'b0;
      end else if (cmd_i.rd_cell) begin
        rd_hit_q <= index_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= sweep_q;
    if (cmd_i.capture) begin
      opcode_q <= opcode_i;
      char_q   <= char_code_i;
      index_q  <= cell_index_i;
    end
    if (cmd_i.load_out) begin
      cursor_column_o <= COL_OUT_W'(col_q);
      cursor_row_o    <= ROW_OUT_W'(row_q);
      cell_data_o     <= rd_hit_q ? ram_rdata : '0;
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire

[rtl/core/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire tcw_sts_t sts_i,
  output tcw_cmd_t      cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_CLEAR  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_PUT: begin
            cmd_o.exec_put = 1'b1;
            state_d        = sts_i.scroll_need ? S_SCROLL : S_DONE;
          end
          OP_BACKSPACE: begin
            cmd_o.exec_bs = 1'b1;
            state_d       = S_DONE;
          end
          OP_CLEAR: begin
            cmd_o.exec_clear = 1'b1;
            state_d          = S_CLEAR;
          end
          OP_READ: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCROLL: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) state_d = S_DRAIN;
      end
      // let the last copy write land before the bottom row is blanked
      S_DRAIN: state_d = S_FILL;
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/text_console_writer_core.sv]
// Text console engine: a COLUMNS x ROWS screen of 16-bit cells (colour byte
// high, character low) in a single-port-write RAM, plus a cursor. Each
// request (put character, backspace, clear, read cell) returns one result
// with the cursor after the operation and, for a read, the cell. Put,
// backspace and read go from acceptance through decode and result back to
// idle, the result state waiting while an earlier result is untaken; a put
// that runs off the bottom row scrolls the RAM one cell per cycle through
// its one read and one write port; clear walks every cell. After reset the
// block blanks the RAM with in_ready_o low; text_color writes are taken
// throughout. A finished result sits in the output register while the next
// request is accepted; only a second result waits for out_ready_i.
`default_nettype none

module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [COLOR_W-1:0]   cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OPCODE_W-1:0]  opcode_i,
  input  wire logic [CHAR_W-1:0]    char_code_i,
  input  wire logic [INDEX_W-1:0]   cell_index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [COL_OUT_W-1:0] cursor_column_o,
  output logic      [ROW_OUT_W-1:0] cursor_row_o,
  output logic      [CELL_W-1:0]    cell_data_o
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .cell_data_o    (cell_data_o)
  );

endmodule

`default_nettype wire

[rtl/core/tcw_checker.sv]
`default_nettype none

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [COL_OUT_W-1:0] cursor_column_o,
  input wire logic [ROW_OUT_W-1:0] cursor_row_o,
  input wire logic [CELL_W-1:0]    cell_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(cursor_column_o) && $stable(cursor_row_o) && $stable(cell_data_o))
    else $error("result changed while stalled");

  // one request in flight: nothing is accepted in the cycle after acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_column_o) < COLUMNS) && (32'(cursor_row_o) < ROWS))
    else $error("cursor outside the screen");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .cursor_column_o(cursor_column_o),
  .cursor_row_o   (cursor_row_o),
  .cell_data_o    (cell_data_o)
);

`default_nettype wire
